// ===== design/lgs_pkg.sv =====
`default_nettype none

package lgs_pkg;

  localparam int MODE_W    = 2;
  localparam int ROW_IDX_W = 4;
  localparam int ROW_W     = 16;
  localparam int IN_W      = 24;
  localparam int ROW_VIEW  = 1 << ROW_IDX_W;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/life_grid_generation_step.sv =====
`default_nettype none
// channel | dir | tdata fields, lowest bit up
// s_*     | in  | mode[1:0], row_index[5:2], row_cells[21:6], zero pad[23:22]
// m_*     | out | row_out[15:0]
//
// One request per cycle while s_tready is high; its result is registered and shows in the next cycle.
// A step updates every row cell at once from its neighbors in that cycle.
// Reset clears the whole grid and drops m_tvalid.
// s_tready drops only while a result is held and m_tready is low.

module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,  // mode, row_index, row_cells
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [ROW_W-1:0] m_tdata   // row_out
);

  mode_t                mode;
  logic [ROW_IDX_W-1:0] row_index;
  logic [ROW_W-1:0]     row_cells;
  logic                 fire;
  logic [COLS-1:0]      wr_cells;
  logic [COLS-1:0]      grid_row  [ROWS];
  logic [COLS-1:0]      grid_next [ROWS];
  cell_ctrl_t           ctrl      [ROWS];
  logic [ROW_W-1:0]     view      [ROW_VIEW];
  logic [ROW_W-1:0]     step_row0;
  logic [ROW_W-1:0]     wr_view;
  logic [ROW_W-1:0]     result_next;
  logic                 is_write;
  logic                 is_step;

  assign mode      = mode_t'(s_tdata[MODE_W-1:0]);
  assign row_index = s_tdata[MODE_W+ROW_IDX_W-1:MODE_W];
  assign row_cells = s_tdata[MODE_W+ROW_IDX_W+ROW_W-1:MODE_W+ROW_IDX_W];
  assign fire      = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;

  generate
    if (COLS > ROW_W) begin : g_wide
      assign wr_cells  = {{(COLS-ROW_W){1'b0}}, row_cells};
      assign step_row0 = grid_next[0][ROW_W-1:0];
    end else if (COLS == ROW_W) begin : g_equal
      assign wr_cells  = row_cells;
      assign step_row0 = grid_next[0];
    end else begin : g_narrow
      assign wr_cells  = row_cells[COLS-1:0];
      assign step_row0 = {{(ROW_W-COLS){1'b0}}, grid_next[0]};
    end
  endgenerate

  generate
    if (COLS >= ROW_W) begin : g_wrv_wide
      assign wr_view = wr_cells[ROW_W-1:0];
    end else begin : g_wrv_narrow
      assign wr_view = {{(ROW_W-COLS){1'b0}}, wr_cells};
    end
  endgenerate

  always_comb begin
    is_write    = 1'b0;
    is_step     = 1'b0;
    result_next = view[row_index];
    unique case (mode)
      MODE_WRITE: begin
        is_write = 1'b1;
        if (32'(row_index) < ROWS) begin
          result_next = wr_view;
        end else begin
          result_next = '0;
        end
      end
      MODE_STEP: begin
        is_step     = 1'b1;
        result_next = step_row0;
      end
      default: begin
        result_next = view[row_index];
      end
    endcase
  end

  genvar r;
  generate
    for (r = 0; r < ROWS; r++) begin : g_cell
      logic [COLS-1:0] up_row;
      logic [COLS-1:0] dn_row;

      if (r == 0) begin : g_top
        assign up_row = '0;
      end else begin : g_up
        assign up_row = grid_row[r-1];
      end
      if (r == ROWS - 1) begin : g_bot
        assign dn_row = '0;
      end else begin : g_dn
        assign dn_row = grid_row[r+1];
      end

      assign ctrl[r].load = fire && is_write && (32'(row_index) == r);
      assign ctrl[r].step = fire && is_step;

      lgs_row_cell #(
        .COLS(COLS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl[r]),
        .wr_cells(wr_cells),
        .up_row  (up_row),
        .dn_row  (dn_row),
        .row     (grid_row[r]),
        .row_next(grid_next[r])
      );
    end
  endgenerate

  genvar v;
  generate
    for (v = 0; v < ROW_VIEW; v++) begin : g_view
      if (v >= ROWS) begin : g_none
        assign view[v] = '0;
      end else if (COLS >= ROW_W) begin : g_wide
        assign view[v] = grid_row[v][ROW_W-1:0];
      end else begin : g_narrow
        assign view[v] = {{(ROW_W-COLS){1'b0}}, grid_row[v]};
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (fire) begin
      m_tdata <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("accepted request produced no result");

  a_write_shows: assert property (@(posedge clk) disable iff (rst)
    fire && is_write |=> m_tdata == view[$past(row_index)])
    else $error("write result differs from stored row");

  a_step_row0: assert property (@(posedge clk) disable iff (rst)
    fire && is_step |=> m_tdata == view[0])
    else $error("step result differs from new row 0");

  a_read_stable: assert property (@(posedge clk) disable iff (rst)
    fire && !is_write && !is_step |=> m_tdata == $past(view[row_index]))
    else $error("read result differs from row");
`endif

endmodule

`default_nettype wire

// ===== design/lgs_row_cell.sv =====
`default_nettype none

module lgs_row_cell
  import lgs_pkg::*;
#(
  parameter int COLS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cell_ctrl_t      ctrl,
  input  wire logic [COLS-1:0] wr_cells,
  input  wire logic [COLS-1:0] up_row,
  input  wire logic [COLS-1:0] dn_row,
  output logic      [COLS-1:0] row,
  output logic      [COLS-1:0] row_next
);

  logic [COLS+1:0] up_p;
  logic [COLS+1:0] mid_p;
  logic [COLS+1:0] dn_p;

  assign up_p  = {1'b0, up_row, 1'b0};
  assign mid_p = {1'b0, row, 1'b0};
  assign dn_p  = {1'b0, dn_row, 1'b0};

  always_comb begin
    logic [3:0] n;
    row_next = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
        + 4'(mid_p[c]) + 4'(mid_p[c+2])
        + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
      if (row[c]) begin
        row_next[c] = (n == BIRTH_COUNT) || (n == SURVIVE_COUNT);
      end else begin
        row_next[c] = (n == BIRTH_COUNT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (ctrl.load) begin
      row <= wr_cells;
    end else if (ctrl.step) begin
      row <= row_next;
    end
  end

endmodule

`default_nettype wire
